### hdl/frame_difference_motion_detector_core_macros.svh
// assertion macros for the frame difference motion detector
// used by the rtl files that carry concurrent checks, no other dependencies
`ifndef FRAME_DIFFERENCE_MOTION_DETECTOR_CORE_MACROS_SVH
`define FRAME_DIFFERENCE_MOTION_DETECTOR_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define FDMD_ASSERT(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("fdmd check failed");
`define FDMD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fdmd check failed");
`else
`define FDMD_ASSERT(lbl, clk, rst_n, expr)
`define FDMD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

### hdl/fdmd_pkg.sv
// shared types and constants of the frame difference motion detector
// no dependencies
`default_nettype none
package fdmd_pkg;
	localparam int MAX_PIXELS = 65536;
	localparam int PIX_AW     = $clog2(MAX_PIXELS);
	localparam int PIX_W      = 8;
	localparam int CNT_W      = 17;
	localparam int PCT_W      = 7;
	localparam int EVERY_W    = 8;
	localparam int CFG_W      = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int IDX_CMP_W  = ((PIX_AW > CNT_W) ? PIX_AW : CNT_W) + 1;
	localparam int BTHR_W     = PCT_W + PIX_W;
	localparam int PROD_W     = PCT_W + CNT_W;
	localparam int CMP_W      = PROD_W + 1;
	localparam int RES_DEPTH  = 4;
	localparam int RES_PTR_W  = $clog2(RES_DEPTH);
	localparam int RES_CNT_W  = RES_PTR_W + 1;

	localparam logic [PCT_W-1:0]   BRIGHT_RST = PCT_W'(5);
	localparam logic [PCT_W-1:0]   OVER_RST   = PCT_W'(50);
	localparam logic [EVERY_W-1:0] EVERY_RST  = EVERY_W'(1);
	localparam logic [CNT_W-1:0]   FPIX_RST   = CNT_W'(19200);
	localparam logic [BTHR_W-1:0]  BTHR_RST   = BTHR_W'(5 * 255);
	localparam logic [PROD_W-1:0]  BLIM_RST   = PROD_W'(5 * 19200);
	localparam logic [PROD_W-1:0]  OLIM_RST   = PROD_W'(50 * 19200);

	typedef enum logic [1:0] {
		CLASS_QUIET    = 2'd0,
		CLASS_MOTION   = 2'd1,
		CLASS_OVERLOAD = 2'd2
	} frame_class_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BRIGHTNESS    = 2'd0,
		REG_OVERLOAD      = 2'd1,
		REG_ANALYSE_EVERY = 2'd2,
		REG_FRAME_PIXELS  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		frame_class_t           frame_class;
		logic [CNT_W-1:0]       changed_count;
	} result_t;
endpackage
`default_nettype wire

### hdl/fdmd_ref_ram.sv
// single port reference frame ram, read-before-write, registered read data
// no dependencies
`default_nettype none
module fdmd_ref_ram #(
	parameter int ADDR_W = 16,
	parameter int DATA_W = 8
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [DATA_W-1:0] wdata,
	output logic      [DATA_W-1:0] rdata
);
	localparam int DEPTH = 1 << ADDR_W;

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

### hdl/fdmd_result_fifo.sv
// small result queue in front of the output channel
// depends on fdmd_pkg
`default_nettype none
module fdmd_result_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire fdmd_pkg::result_t wdata,
	input  wire logic              pop,
	output logic                   valid,
	output fdmd_pkg::result_t      rdata
);
	fdmd_pkg::result_t                      entry_q [fdmd_pkg::RES_DEPTH];
	logic [fdmd_pkg::RES_PTR_W-1:0]         wr_ptr_q;
	logic [fdmd_pkg::RES_PTR_W-1:0]         rd_ptr_q;
	logic [fdmd_pkg::RES_CNT_W-1:0]         count_q;
	logic                                   do_pop;

	assign valid  = (count_q != '0);
	assign rdata  = entry_q[rd_ptr_q];
	assign do_pop = pop && valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule
`default_nettype wire

### hdl/frame_difference_motion_detector_core.sv
// frame difference motion detector, top level
// depends on fdmd_pkg, fdmd_ref_ram, fdmd_result_fifo and the macros header
//
// channel  dir  handshake          word
// -------  ---  -----------------  -----------------------------------
// input    in   in_valid/in_stall   pixel_value
// output   out  out_valid/out_stall frame_class, changed_count
// config   in   cfg_write           cfg_index, cfg_data (no read-back)
//
// one pixel per clock sustained; the reference ram does one read and, in an analysed
// frame, one write to the same address in the accept cycle (read-before-write), so
// no forwarding is needed. a result passes the stage 1 and stage 2
// registers into the result queue. asynchronous active-low reset, no clearing pass: the
// first analysed frame only writes the reference; comparing starts with the next one.
// input stalls only at the last pixel of a reporting frame while the
// result queue and the in-flight results together are full.
`default_nettype none
`include "frame_difference_motion_detector_core_macros.svh"
module frame_difference_motion_detector_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// pixel input
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [fdmd_pkg::PIX_W-1:0]     pixel_value,
	// result output
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [1:0]                          frame_class,
	output logic [fdmd_pkg::CNT_W-1:0]          changed_count,
	// configuration writes
	input  wire logic                           cfg_write,
	input  wire logic [fdmd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [fdmd_pkg::CFG_W-1:0]     cfg_data
);
	// configuration registers
	logic [fdmd_pkg::PCT_W-1:0]   bright_q;
	logic [fdmd_pkg::PCT_W-1:0]   over_q;
	logic [fdmd_pkg::EVERY_W-1:0] every_q;
	logic [fdmd_pkg::CNT_W-1:0]   fpix_q;

	// derived thresholds, recomputed every cycle from the registers
	logic [fdmd_pkg::BTHR_W-1:0]  bthr_q;   // brightness * 255
	logic [fdmd_pkg::PROD_W-1:0]  blim_q;   // brightness * frame length
	logic [fdmd_pkg::PROD_W-1:0]  olim_q;   // overload * frame length

	// frame position state
	logic [fdmd_pkg::PIX_AW-1:0]  idx_q;
	logic [fdmd_pkg::EVERY_W-1:0] phase_q;
	logic                         rv_q;

	// counting state, owned by stage 1
	logic [fdmd_pkg::CNT_W-1:0]   cnt_q;
	logic                         ovl_q;

	// results accepted but not yet taken
	logic [fdmd_pkg::RES_CNT_W-1:0] pending_q;

	// accept stage
	logic [fdmd_pkg::CNT_W-1:0]   total;
	logic [fdmd_pkg::EVERY_W-1:0] every_eff;
	logic                         analysed_a;
	logic                         last_a;
	logic                         emit_a;
	logic                         accept_a;

	// stage 1
	logic                         v_s1;
	logic [fdmd_pkg::PIX_W-1:0]   pix_s1;
	logic                         an_s1;
	logic                         rv_s1;
	logic                         last_s1;
	logic                         emit_s1;
	logic [fdmd_pkg::PIX_W-1:0]   ref_s1;
	logic [fdmd_pkg::PIX_W-1:0]   diff_s1;
	logic [fdmd_pkg::BTHR_W-1:0]  d100_s1;
	logic                         hit_s1;
	logic [fdmd_pkg::CNT_W-1:0]   cnt_new_s1;
	logic                         ovl_hit_s1;
	logic [fdmd_pkg::CNT_W-1:0]   cnt_fin_s1;
	logic                         ovl_fin_s1;

	// stage 2
	logic                         v_s2;
	logic [fdmd_pkg::CNT_W-1:0]   cnt_s2;
	logic                         ovl_s2;
	logic [fdmd_pkg::CMP_W-1:0]   c100_s2;
	fdmd_pkg::result_t            res_s2;

	fdmd_pkg::result_t            head;
	logic                         take;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q <= fdmd_pkg::BRIGHT_RST;
			over_q   <= fdmd_pkg::OVER_RST;
			every_q  <= fdmd_pkg::EVERY_RST;
			fpix_q   <= fdmd_pkg::FPIX_RST;
		end else if (cfg_write) begin
			case (fdmd_pkg::cfg_reg_t'(cfg_index))
				fdmd_pkg::REG_BRIGHTNESS:    bright_q <= cfg_data[fdmd_pkg::PCT_W-1:0];
				fdmd_pkg::REG_OVERLOAD:      over_q   <= cfg_data[fdmd_pkg::PCT_W-1:0];
				fdmd_pkg::REG_ANALYSE_EVERY: every_q  <= cfg_data[fdmd_pkg::EVERY_W-1:0];
				fdmd_pkg::REG_FRAME_PIXELS:  fpix_q   <= cfg_data[fdmd_pkg::CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// frame length clamped to 1..MAX_PIXELS, interval zero acts as one
	always_comb begin
		if (fpix_q == '0) begin
			total = fdmd_pkg::CNT_W'(1);
		end else if (fdmd_pkg::IDX_CMP_W'(fpix_q) >
				fdmd_pkg::IDX_CMP_W'(fdmd_pkg::MAX_PIXELS)) begin
			total = fdmd_pkg::CNT_W'(fdmd_pkg::MAX_PIXELS);
		end else begin
			total = fpix_q;
		end
	end

	assign every_eff = (every_q == '0) ? fdmd_pkg::EVERY_W'(1) : every_q;

	// threshold products, registered; user changes config only while idle (not enforced)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bthr_q <= fdmd_pkg::BTHR_RST;
			blim_q <= fdmd_pkg::BLIM_RST;
			olim_q <= fdmd_pkg::OLIM_RST;
		end else begin
			bthr_q <= fdmd_pkg::BTHR_W'(bright_q) * fdmd_pkg::BTHR_W'(255);
			blim_q <= fdmd_pkg::PROD_W'(bright_q) * fdmd_pkg::PROD_W'(total);
			olim_q <= fdmd_pkg::PROD_W'(over_q) * fdmd_pkg::PROD_W'(total);
		end
	end

	// ---------------- accept stage ----------------
	assign analysed_a = ({1'b0, phase_q} + 1'b1) >= {1'b0, every_eff};
	assign last_a     = (fdmd_pkg::IDX_CMP_W'(idx_q) + 1'b1) >= fdmd_pkg::IDX_CMP_W'(total);
	assign emit_a     = analysed_a && last_a && rv_q;

	// hold the reporting pixel back while every result slot is spoken for
	assign in_stall = emit_a && (pending_q == fdmd_pkg::RES_CNT_W'(fdmd_pkg::RES_DEPTH));
	assign accept_a = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			phase_q <= '0;
			rv_q    <= 1'b0;
		end else if (accept_a) begin
			if (last_a) begin
				idx_q <= '0;
				if (analysed_a) begin
					phase_q <= '0;
					rv_q    <= 1'b1;
				end else begin
					phase_q <= phase_q + 1'b1;
				end
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// reference store: old value read out while the new pixel goes in
	fdmd_ref_ram #(
		.ADDR_W (fdmd_pkg::PIX_AW),
		.DATA_W (fdmd_pkg::PIX_W)
	) u_ref_ram (
		.clk   (clk),
		.we    (accept_a && analysed_a),
		.addr  (idx_q),
		.wdata (pixel_value),
		.rdata (ref_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept_a;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_a) begin
			pix_s1  <= pixel_value;
			an_s1   <= analysed_a;
			rv_s1   <= rv_q;
			last_s1 <= last_a;
			emit_s1 <= emit_a;
		end
	end

	// ---------------- stage 1: compare and count ----------------
	assign diff_s1 = (pix_s1 > ref_s1) ? (pix_s1 - ref_s1) : (ref_s1 - pix_s1);
	assign d100_s1 = fdmd_pkg::BTHR_W'(diff_s1) * fdmd_pkg::BTHR_W'(100);

	// diff > floor(b*255/100) is the same as 100*diff > b*255
	assign hit_s1 = v_s1 && an_s1 && rv_s1 && !ovl_q && (d100_s1 > bthr_q);

	// count reaches floor(o*T/100) exactly when 100*(count+1) > o*T
	assign cnt_new_s1 = cnt_q + 1'b1;
	assign ovl_hit_s1 = ((fdmd_pkg::CMP_W'(cnt_new_s1) + 1'b1) * fdmd_pkg::CMP_W'(100)) >
		fdmd_pkg::CMP_W'(olim_q);

	assign cnt_fin_s1 = hit_s1 ? cnt_new_s1 : cnt_q;
	assign ovl_fin_s1 = ovl_q || (hit_s1 && ovl_hit_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovl_q <= 1'b0;
		end else if (v_s1) begin
			if (last_s1) begin
				cnt_q <= '0;
				ovl_q <= 1'b0;
			end else begin
				cnt_q <= cnt_fin_s1;
				ovl_q <= ovl_fin_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && emit_s1) begin
			cnt_s2 <= cnt_fin_s1;
			ovl_s2 <= ovl_fin_s1;
		end
	end

	// ---------------- stage 2: classify ----------------
	assign c100_s2 = fdmd_pkg::CMP_W'(cnt_s2) * fdmd_pkg::CMP_W'(100);

	always_comb begin
		res_s2.changed_count = cnt_s2;
		if (ovl_s2) begin
			res_s2.frame_class = fdmd_pkg::CLASS_OVERLOAD;
		end else if ((c100_s2 > fdmd_pkg::CMP_W'(blim_q)) &&
				(c100_s2 < fdmd_pkg::CMP_W'(olim_q))) begin
			res_s2.frame_class = fdmd_pkg::CLASS_MOTION;
		end else begin
			res_s2.frame_class = fdmd_pkg::CLASS_QUIET;
		end
	end

	fdmd_result_fifo u_result_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (v_s2),
		.wdata  (res_s2),
		.pop    (!out_stall),
		.valid  (out_valid),
		.rdata  (head)
	);

	assign frame_class   = head.frame_class;
	assign changed_count = head.changed_count;
	assign take          = out_valid && !out_stall;

	// results counted from pixel accept until the word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			case ({accept_a && emit_a, take})
				2'b10:   pending_q <= pending_q + 1'b1;
				2'b01:   pending_q <= pending_q - 1'b1;
				default: pending_q <= pending_q;
			endcase
		end
	end

	// ---------------- checks ----------------
	`FDMD_ASSERT(a_pending_bound, clk, arst_n, pending_q <= fdmd_pkg::RES_CNT_W'(fdmd_pkg::RES_DEPTH))
	`FDMD_ASSERT_IMPL(a_out_has_credit, clk, arst_n, out_valid, pending_q != '0)
	`FDMD_ASSERT_IMPL(a_push_has_credit, clk, arst_n, v_s2, pending_q != '0)
	`FDMD_ASSERT_IMPL(a_ovl_from_hit, clk, arst_n, $rose(ovl_q), $past(hit_s1))
	`FDMD_ASSERT_IMPL(a_no_count_after_ovl, clk, arst_n, ovl_q && v_s1, !hit_s1)
endmodule
`default_nettype wire

### test/tb_top.sv
// testbench for frame_difference_motion_detector_core: pixel streams with a
// per-pixel prediction of the frame reports, checked word by word
// depends on fdmd_pkg and the rtl of the core
`timescale 1ns / 100ps
module tb_top;
	localparam int RANDOM_ITEMS = 1000;  // rough size of the random part
	localparam int FILL_LEN     = 256;   // reference entries written up front
	localparam int PAUSE_MAX    = 10;    // longest per-word gap or stall
	localparam int DRAIN_CYCLES = 16;    // extra wait after the last report is checked
	localparam int STUCK_LIMIT  = 1000;  // cycles without any handshake

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// block ports, all known from time zero
	logic                           in_valid    = 1'b0;
	logic                           in_stall;
	logic [fdmd_pkg::PIX_W-1:0]     pixel_value = '0;
	logic                           out_valid;
	logic                           out_stall   = 1'b0;
	logic [1:0]                     frame_class;
	logic [fdmd_pkg::CNT_W-1:0]     changed_count;
	logic                           cfg_write   = 1'b0;
	logic [fdmd_pkg::CFG_IDX_W-1:0] cfg_index   = '0;
	logic [fdmd_pkg::CFG_W-1:0]     cfg_data    = '0;

	// stimulus side: pixels waiting to go out, plus a mirror of the frame position
	logic [fdmd_pkg::PIX_W-1:0] pixel_feed [$];
	bit   [fdmd_pkg::PIX_W-1:0] scene [fdmd_pkg::MAX_PIXELS];
	logic [fdmd_pkg::CFG_W-1:0] feed_len = fdmd_pkg::FPIX_RST;
	int unsigned      feed_idx = 0;
	bit               send_idle_on = 1'b0;
	bit               recv_idle_on = 1'b0;
	int unsigned      send_gap = 0;
	int unsigned      stall_left = 0;

	// detector state as the testbench sees it
	logic [fdmd_pkg::PIX_W-1:0]   ref_pix [fdmd_pkg::MAX_PIXELS];
	int unsigned                  pix_idx = 0;
	int unsigned                  chg_cnt = 0;
	bit                           overload_hit = 1'b0;
	bit                           ref_filled = 1'b0;
	int unsigned                  skip_phase = 0;
	logic [fdmd_pkg::PCT_W-1:0]   bright_pct = fdmd_pkg::BRIGHT_RST;
	logic [fdmd_pkg::PCT_W-1:0]   over_pct   = fdmd_pkg::OVER_RST;
	logic [fdmd_pkg::EVERY_W-1:0] every_n    = fdmd_pkg::EVERY_RST;
	logic [fdmd_pkg::CNT_W-1:0]   frame_len  = fdmd_pkg::FPIX_RST;

	// frame reports still owed by the block, oldest first
	fdmd_pkg::result_t frames_due [$];

	// bookkeeping
	int unsigned pixels_taken = 0;
	int unsigned reports_checked = 0;
	int unsigned reg_writes = 0;
	int unsigned fail_count = 0;
	int unsigned quiet_cycles = 0;

	frame_difference_motion_detector_core DUT (.*);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned pause_draw(input bit enabled);
		return enabled ? $urandom_range(0, PAUSE_MAX) : 0;
	endfunction

	// advance the detector by one accepted pixel; queue a report at the end
	// of a compared frame
	task automatic classify_pixel(input logic [fdmd_pkg::PIX_W-1:0] pix);
		int unsigned interval, total, pos, thr, diff;
		longint unsigned limit, c100;
		bit analysed, last;
		fdmd_pkg::frame_class_t cls;
		fdmd_pkg::result_t report;
		interval = (every_n == 0) ? 1 : every_n;        // zero interval acts as one
		total = (frame_len == 0) ? 1 : frame_len;       // frame length clamped to 1..max
		if (total > fdmd_pkg::MAX_PIXELS)
			total = fdmd_pkg::MAX_PIXELS;
		analysed = (skip_phase + 1 >= interval);
		last = (pix_idx + 1 >= total);                  // also ends a frame that shrank
		pos = pix_idx % fdmd_pkg::MAX_PIXELS;
		if (analysed) begin
			if (ref_filled && !overload_hit) begin
				diff = (pix > ref_pix[pos]) ? pix - ref_pix[pos] : ref_pix[pos] - pix;
				thr = (32'(bright_pct) * 255) / 100;
				if (diff > thr) begin
					limit = (64'(over_pct) * total) / 100;
					chg_cnt++;
					if (chg_cnt >= limit)
						overload_hit = 1'b1;        // counting freezes here
				end
			end
			ref_pix[pos] = pix;
		end
		if (last) begin
			if (analysed) begin
				if (ref_filled) begin
					c100 = 64'(chg_cnt) * 100;
					if (overload_hit)
						cls = fdmd_pkg::CLASS_OVERLOAD;
					else if (c100 > 64'(bright_pct) * total &&
							c100 < 64'(over_pct) * total)
						cls = fdmd_pkg::CLASS_MOTION;
					else
						cls = fdmd_pkg::CLASS_QUIET;
					report.frame_class = cls;
					report.changed_count = fdmd_pkg::CNT_W'(chg_cnt);
					frames_due.push_back(report);
				end
				ref_filled = 1'b1;
				skip_phase = 0;
			end else begin
				skip_phase = (skip_phase + 1) & 8'hFF;
			end
			pix_idx = 0;
			chg_cnt = 0;
			overload_hit = 1'b0;
		end else begin
			pix_idx++;
		end
	endtask

	// sender: one pixel word at a time, random gap after each word while send_idle_on is set
	always @(posedge clk) begin
		if (arst_n && (!in_valid || !in_stall)) begin
			if (send_gap != 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pixel_feed.size() != 0) begin
				in_valid    <= 1'b1;
				pixel_value <= pixel_feed.pop_front();
				send_gap    <= pause_draw(send_idle_on);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// accepted pixels and register writes feed the prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_write) begin
				case (fdmd_pkg::cfg_reg_t'(cfg_index))
					fdmd_pkg::REG_BRIGHTNESS:
						bright_pct = cfg_data[fdmd_pkg::PCT_W-1:0];
					fdmd_pkg::REG_OVERLOAD:
						over_pct   = cfg_data[fdmd_pkg::PCT_W-1:0];
					fdmd_pkg::REG_ANALYSE_EVERY:
						every_n    = cfg_data[fdmd_pkg::EVERY_W-1:0];
					fdmd_pkg::REG_FRAME_PIXELS:
						frame_len  = cfg_data[fdmd_pkg::CNT_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				classify_pixel(pixel_value);
				pixels_taken++;
			end
		end
	end

	// receiver: compare each report word, then stall for a random while if recv_idle_on is set
	always @(posedge clk) begin
		int unsigned hold;
		fdmd_pkg::result_t want;
		hold = stall_left;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (frames_due.size() == 0) begin
					$error("report with none pending: frame_class %0d changed_count %0d",
						frame_class, changed_count);
					fail_count++;
				end else begin
					want = frames_due.pop_front();
					if (frame_class !== want.frame_class) begin
						$error("frame_class mismatch: expected %0d, actual %0d",
							want.frame_class, frame_class);
						fail_count++;
					end
					if (changed_count !== want.changed_count) begin
						$error("changed_count mismatch: expected %0d, actual %0d",
							want.changed_count, changed_count);
						fail_count++;
					end
				end
				reports_checked++;
				hold = pause_draw(recv_idle_on);
			end
			out_stall  <= (hold != 0);
			stall_left <= (hold != 0) ? hold - 1 : 0;
		end
	end

	// cycles since the last handshake of any kind
	always @(posedge clk) begin
		if (!arst_n || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < STUCK_LIMIT)
			@(posedge clk);
		$display("watchdog: no handshake for %0d cycles", STUCK_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	// one register write, returns on a falling edge
	task automatic write_reg(input fdmd_pkg::cfg_reg_t idx, input int unsigned value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= fdmd_pkg::CFG_W'(value);
		@(posedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
		if (idx == fdmd_pkg::REG_FRAME_PIXELS)
			feed_len = fdmd_pkg::CFG_W'(value);
		reg_writes++;
	endtask

	task automatic push_pixel(input logic [fdmd_pkg::PIX_W-1:0] pix);
		int unsigned span;
		span = (feed_len == 0) ? 1 :
			((feed_len > fdmd_pkg::MAX_PIXELS) ? fdmd_pkg::MAX_PIXELS : feed_len);
		pixel_feed.push_back(pix);
		scene[feed_idx % fdmd_pkg::MAX_PIXELS] = pix;
		feed_idx = (feed_idx + 1 >= span) ? 0 : feed_idx + 1;
	endtask

	// pixels close to the last scene, a share of them replaced by noise;
	// a negative share means a fresh share for every frame
	task automatic feed_pixels(input int unsigned count, input int change_pct);
		int pct, v;
		pct = (change_pct < 0) ? 10 : change_pct;
		for (int k = 0; k < count; k++) begin
			if (change_pct < 0 && feed_idx == 0) begin
				case ($urandom_range(0, 4))
					0: pct = 0;
					1: pct = 3;
					2: pct = 15;
					3: pct = 60;
					default: pct = 100;
				endcase
			end
			if ($urandom_range(0, 99) < pct) begin
				v = $urandom_range(0, 255);
			end else begin
				v = int'(scene[feed_idx % fdmd_pkg::MAX_PIXELS]) +
					int'($urandom_range(0, 4)) - 2;
				if (v < 0)
					v = 0;
				if (v > 255)
					v = 255;
			end
			push_pixel(fdmd_pkg::PIX_W'(v));
		end
	endtask

	// pause until every word is out, every report back and the pipe empty
	task automatic settle();
		do
			@(negedge clk);
		while (pixel_feed.size() != 0 || in_valid || frames_due.size() != 0);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
	endtask

	initial begin
		int unsigned b, o, e, f, interval, total, count, random_fed, phase_no;
		random_fed = 0;
		phase_no = 0;
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// fill the start of the reference first, so no later frame reads an
		// entry that was never written; the first half runs at an oversize
		// length that clamps to the maximum, then the frame shrinks to the fill
		recv_idle_on = 1'b1;
		write_reg(fdmd_pkg::REG_ANALYSE_EVERY, 1);
		write_reg(fdmd_pkg::REG_FRAME_PIXELS, 17'h1FFFF);
		feed_pixels(FILL_LEN / 2, 100);
		settle();
		write_reg(fdmd_pkg::REG_FRAME_PIXELS, FILL_LEN);
		feed_pixels(FILL_LEN - FILL_LEN / 2, 100);
		settle();
		// one compared frame at the fill length
		feed_pixels(FILL_LEN, -1);
		settle();

		// zero pixel threshold, overload percent above 100: pixel extremes,
		// three alternating frames, of which the last two are full swings (motion)
		send_idle_on = 1'b1;
		write_reg(fdmd_pkg::REG_BRIGHTNESS, 0);
		write_reg(fdmd_pkg::REG_OVERLOAD, 127);
		write_reg(fdmd_pkg::REG_FRAME_PIXELS, 4);
		for (int k = 0; k < 12; k++)
			push_pixel((k % 2 == (k / 4) % 2) ? 8'h00 : 8'hFF);
		settle();

		// zero overload limit flags overload at the first changed pixel;
		// zero frame length acts as one pixel
		write_reg(fdmd_pkg::REG_OVERLOAD, 0);
		write_reg(fdmd_pkg::REG_BRIGHTNESS, 1);
		write_reg(fdmd_pkg::REG_FRAME_PIXELS, 0);
		push_pixel(8'h00);
		push_pixel(8'h00);
		push_pixel(8'hC8);
		settle();

		// threshold above any difference, zero interval acts as one
		write_reg(fdmd_pkg::REG_BRIGHTNESS, 127);
		write_reg(fdmd_pkg::REG_OVERLOAD, 100);
		write_reg(fdmd_pkg::REG_ANALYSE_EVERY, 0);
		write_reg(fdmd_pkg::REG_FRAME_PIXELS, 1);
		push_pixel(8'h07);
		push_pixel(8'hFA);
		settle();

		// frame shrinks under a partly sent frame: the next pixel ends it
		write_reg(fdmd_pkg::REG_BRIGHTNESS, 5);
		write_reg(fdmd_pkg::REG_OVERLOAD, 50);
		write_reg(fdmd_pkg::REG_ANALYSE_EVERY, 1);
		write_reg(fdmd_pkg::REG_FRAME_PIXELS, 8);
		feed_pixels(5, 50);
		settle();
		write_reg(fdmd_pkg::REG_FRAME_PIXELS, 3);
		feed_pixels(1, 50);
		settle();

		// random settings, mostly whole frames near the previous scene,
		// some noise frames and some phases that stop inside a frame
		while (random_fed < RANDOM_ITEMS) begin
			if (phase_no == 0)
				e = 255;
			else if ($urandom_range(0, 9) == 0)
				e = $urandom_range(0, 255);
			else
				e = $urandom_range(0, 4);
			if (e > 6)
				f = $urandom_range(0, 1);        // long intervals only on tiny frames
			else if (e <= 1 && $urandom_range(0, 11) == 0)
				f = $urandom_range(100, FILL_LEN);
			else
				f = $urandom_range(0, 40);
			b = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 30);
			o = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(20, 100);
			write_reg(fdmd_pkg::REG_BRIGHTNESS, b);
			write_reg(fdmd_pkg::REG_OVERLOAD, o);
			write_reg(fdmd_pkg::REG_ANALYSE_EVERY, e);
			write_reg(fdmd_pkg::REG_FRAME_PIXELS, f);
			send_idle_on = ($urandom_range(0, 3) != 0);
			recv_idle_on = ($urandom_range(0, 3) != 0);
			interval = (e == 0) ? 1 : e;
			total = (f == 0) ? 1 : f;
			count = (interval * $urandom_range(1, 2) + $urandom_range(0, 1)) * total;
			if (total > 1 && $urandom_range(0, 3) == 0)
				count += $urandom_range(1, total - 1);
			feed_pixels(count, -1);
			random_fed += count;
			settle();
			phase_no++;
		end

		$display("run covered %0d pixels and %0d frame reports", pixels_taken, reports_checked);
		$display("with %0d register writes over %0d random settings", reg_writes, phase_no);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

### filelist.f
+incdir+hdl
hdl/fdmd_pkg.sv
hdl/fdmd_ref_ram.sv
hdl/fdmd_result_fifo.sv
hdl/frame_difference_motion_detector_core.sv
test/tb_top.sv
